[sv/alarm_clock_set_controller_defines.svh]
// ----------------------------------------------------------------------------
// Alarm clock set controller: assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_SET_CONTROLLER_DEFINES_SVH
`define ALARM_CLOCK_SET_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ACSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ACSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/acsc_pkg.sv]
// ----------------------------------------------------------------------------
// Alarm clock set controller package
// Word types, state type, reset constants and field helper functions.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam logic [5:0] SecMax  = 6'd59;
  localparam logic [5:0] MinMax  = 6'd59;
  localparam logic [5:0] HourMax = 6'd23;

  localparam logic [6:0] ThrReset         = 7'd25;
  localparam logic [4:0] AlarmHourReset   = 5'd12;
  localparam logic [5:0] AlarmMinuteReset = 6'd0;
  localparam logic [5:0] AlarmSecondReset = 6'd20;

  // field selector codes
  typedef enum logic [1:0] {
    SelOff    = 2'd0,
    SelSecond = 2'd1,
    SelMinute = 2'd2,
    SelHour   = 2'd3
  } sel_e;

  typedef struct packed {
    logic [5:0]         clock_hour_bcd;
    logic [6:0]         clock_minute_bcd;
    logic [6:0]         clock_second_bcd;
    logic signed [11:0] temp_raw;
    logic               press_time_mode;
    logic               press_alarm_mode;
    logic               press_up;
    logic               press_down;
  } in_t;

  typedef struct packed {
    logic [5:0] set_hour_bcd;
    logic [6:0] set_minute_bcd;
    logic [6:0] set_second_bcd;
    logic       write_clock;
    logic       alarm_ring;
    logic [7:0] temp_degrees;
    logic       over_temp;
    logic [1:0] time_field_sel;
    logic [1:0] alarm_field_sel;
    logic [4:0] alarm_hour_now;
    logic [5:0] alarm_minute_now;
    logic [5:0] alarm_second_now;
  } out_t;

  typedef struct packed {
    sel_e       time_sel;
    sel_e       alarm_sel;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [5:0] alarm_second;
  } state_t;

  // BCD to binary, values above the field maximum clamp to the field maximum
  function automatic logic [5:0] bcd_to_bin(logic [6:0] v, logic [5:0] maxv);
    logic [6:0] b;
    b = 7'(v[6:4]) * 7'd10 + 7'(v[3:0]);
    if (b > {1'b0, maxv}) begin
      return maxv;
    end
    return b[5:0];
  endfunction

  // binary 0..59 to BCD, tens found by compare chain
  function automatic logic [6:0] bin_to_bcd(logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] r;
    priority if (v >= 6'd50) begin
      tens = 3'd5; r = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 3'd4; r = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 3'd3; r = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 3'd2; r = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 3'd1; r = v - 6'd10;
    end else begin
      tens = 3'd0; r = v;
    end
    return {tens, r[3:0]};
  endfunction

  // up first, then down, each wrapping within 0..maxv
  function automatic logic [5:0] edit(logic [5:0] v, logic [5:0] maxv,
                                      logic up, logic down);
    logic [5:0] t;
    t = v;
    if (up) begin
      t = (t >= maxv) ? 6'd0 : t + 6'd1;
    end
    if (down) begin
      t = (t == 6'd0) ? maxv : t - 6'd1;
    end
    return t;
  endfunction

endpackage

[sv/acsc_step.sv]
// ----------------------------------------------------------------------------
// Alarm clock set controller: step logic
// Combinational update of selectors, time and alarm edits, temperature.
// ----------------------------------------------------------------------------
module acsc_step (
  input  acsc_pkg::state_t state_i,
  input  logic [6:0]       thr_i,
  input  acsc_pkg::in_t    in_i,
  output acsc_pkg::state_t state_o,
  output acsc_pkg::out_t   out_o
);

  logic [5:0]  hour, minute, second;
  logic [5:0]  al_hour;
  logic        negative;
  logic [11:0] mag;
  logic [12:0] mag_rnd;
  logic [7:0]  deg;

  always_comb begin
    hour   = acsc_pkg::bcd_to_bin({1'b0, in_i.clock_hour_bcd}, acsc_pkg::HourMax);
    minute = acsc_pkg::bcd_to_bin(in_i.clock_minute_bcd, acsc_pkg::MinMax);
    second = acsc_pkg::bcd_to_bin(in_i.clock_second_bcd, acsc_pkg::SecMax);

    state_o = state_i;
    if (in_i.press_time_mode) begin
      state_o.time_sel = acsc_pkg::sel_e'(2'(state_i.time_sel + 2'd1));
    end
    if (in_i.press_alarm_mode) begin
      state_o.alarm_sel = acsc_pkg::sel_e'(2'(state_i.alarm_sel + 2'd1));
    end

    unique case (state_o.time_sel)
      acsc_pkg::SelSecond: second = acsc_pkg::edit(second, acsc_pkg::SecMax,
                                                   in_i.press_up, in_i.press_down);
      acsc_pkg::SelMinute: minute = acsc_pkg::edit(minute, acsc_pkg::MinMax,
                                                   in_i.press_up, in_i.press_down);
      acsc_pkg::SelHour:   hour   = acsc_pkg::edit(hour, acsc_pkg::HourMax,
                                                   in_i.press_up, in_i.press_down);
      default: ;
    endcase

    al_hour = '0;
    unique case (state_o.alarm_sel)
      acsc_pkg::SelSecond: state_o.alarm_second =
        acsc_pkg::edit(state_i.alarm_second, acsc_pkg::SecMax,
                       in_i.press_up, in_i.press_down);
      acsc_pkg::SelMinute: state_o.alarm_minute =
        acsc_pkg::edit(state_i.alarm_minute, acsc_pkg::MinMax,
                       in_i.press_up, in_i.press_down);
      acsc_pkg::SelHour: begin
        al_hour = acsc_pkg::edit({1'b0, state_i.alarm_hour}, acsc_pkg::HourMax,
                                 in_i.press_up, in_i.press_down);
        state_o.alarm_hour = al_hour[4:0];
      end
      default: ;
    endcase

    // magnitude in sixteenths; -2048 maps to 0x800 through the 12-bit wrap
    negative = in_i.temp_raw[11];
    mag      = negative ? 12'(~in_i.temp_raw + 12'sd1) : in_i.temp_raw;
    mag_rnd  = {1'b0, mag} + 13'd8;
    deg      = mag_rnd[11:4] | {mag_rnd[12], 7'd0};

    out_o.set_hour_bcd     = 6'(acsc_pkg::bin_to_bcd(hour));
    out_o.set_minute_bcd   = acsc_pkg::bin_to_bcd(minute);
    out_o.set_second_bcd   = acsc_pkg::bin_to_bcd(second);
    out_o.write_clock      = (state_o.time_sel != acsc_pkg::SelOff);
    out_o.alarm_ring       = (hour == {1'b0, state_o.alarm_hour}) &&
                             (minute == state_o.alarm_minute) &&
                             (second == state_o.alarm_second);
    out_o.temp_degrees     = deg;
    out_o.over_temp        = !negative && (deg >= {1'b0, thr_i});
    out_o.time_field_sel   = state_o.time_sel;
    out_o.alarm_field_sel  = state_o.alarm_sel;
    out_o.alarm_hour_now   = state_o.alarm_hour;
    out_o.alarm_minute_now = state_o.alarm_minute;
    out_o.alarm_second_now = state_o.alarm_second;
  end

endmodule

[sv/alarm_clock_set_controller.sv]
// ----------------------------------------------------------------------------
// Alarm clock set controller
// Time/alarm field editing, alarm match and temperature rounding per word.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o   | acsc_pkg::in_t
//  out     | out | out_valid_o/out_ready_i | acsc_pkg::out_t
//  cfg     | in  | cfg_valid_i/cfg_ready_o | 7-bit over-temperature threshold
//
// Path from input accept to result: input register, step logic, result register;
// a stalled output can hold the word in the input register.
// One word per cycle sustained while the output is taken; state updates when a
// word moves from the input register to the result register.
// Reset returns selectors to off and the alarm to 12:00:20, threshold 25.
// A stalled output holds the input register; in_ready_o drops only when both
// registers are full and the output is not taken.
`include "alarm_clock_set_controller_defines.svh"

module alarm_clock_set_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  acsc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output acsc_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [6:0]     cfg_data_i
);

  logic             in_valid_q, out_valid_q;
  acsc_pkg::in_t    in_q;
  acsc_pkg::out_t   out_q, out_d;
  acsc_pkg::state_t state_q, state_d;
  logic [6:0]       thr_q;
  logic             advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  acsc_step u_step (
    .state_i (state_q),
    .thr_i   (thr_q),
    .in_i    (in_q),
    .state_o (state_d),
    .out_o   (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
      thr_q                  <= acsc_pkg::ThrReset;
      state_q.time_sel       <= acsc_pkg::SelOff;
      state_q.alarm_sel      <= acsc_pkg::SelOff;
      state_q.alarm_hour     <= acsc_pkg::AlarmHourReset;
      state_q.alarm_minute   <= acsc_pkg::AlarmMinuteReset;
      state_q.alarm_second   <= acsc_pkg::AlarmSecondReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  `ACSC_ASSERT_NOW(a_full_stall_blocks_input, clk_i, rst_ni,
                   in_valid_q && out_valid_q && !out_ready_i, !in_ready_o,
                   "input accepted while both stages are full and stalled")
  `ACSC_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni,
                    advance, out_valid_q,
                    "result register empty after a word advanced")
  `ACSC_ASSERT_NEXT(a_state_moves_on_advance, clk_i, rst_ni,
                    !advance, $stable(state_q),
                    "selector or alarm state changed without a word advancing")

endmodule

[verif/tb_alarm_clock_set_controller.sv]
// ----------------------------------------------------------------------------
// Alarm clock set controller testbench
// Drives clock samples, temperature readings and key events through the
// valid/ready input channel and checks every result word against an
// in-bench model of the selectors, the field edits, the alarm match and the
// temperature rounding. A short directed table comes first, then random words
// under three idle patterns and several over-temperature thresholds.
// ----------------------------------------------------------------------------
module tb_alarm_clock_set_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import acsc_pkg::*;

  localparam int StallLimit = 2000;
  localparam int ChunkWords = 275;
  localparam int NumChunks  = 6;

  typedef struct {
    in_t  w;
    bit   has_lit;
    out_t lit;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_t        in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i = '0;

  // model state
  sel_e       time_sel_q = SelOff;
  sel_e       alarm_sel_q = SelOff;
  logic [4:0] al_hour = AlarmHourReset;
  logic [5:0] al_minute = AlarmMinuteReset;
  logic [5:0] al_second = AlarmSecondReset;
  logic [6:0] thr_q = ThrReset;

  out_t expected_words[$];
  row_t plan[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int n_err = 0;
  int n_in = 0;
  int n_out = 0;
  int n_cfg = 0;
  int n_ring = 0;
  int n_over = 0;
  int n_write = 0;

  alarm_clock_set_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [5:0] from_bcd(logic [6:0] v, int unsigned top);
    int unsigned n;
    n = v[6:4] * 10 + v[3:0];
    return (n > top) ? 6'(top) : 6'(n);
  endfunction

  function automatic logic [6:0] to_bcd(int unsigned n);
    return 7'(((n / 10) << 4) | (n % 10));
  endfunction

  function automatic int unsigned nudge(int unsigned v, int unsigned top,
                                        logic up, logic dn);
    if (up) begin
      v = (v >= top) ? 0 : v + 1;
    end
    if (dn) begin
      v = (v == 0) ? top : v - 1;
    end
    return v;
  endfunction

  // advances the model by one word and returns the word it should produce
  function automatic out_t step_clock(in_t w);
    int unsigned hr;
    int unsigned mn;
    int unsigned sc;
    int unsigned raw;
    int unsigned mag;
    int unsigned deg;
    logic        neg;
    out_t        r;
    hr = from_bcd({1'b0, w.clock_hour_bcd}, HourMax);
    mn = from_bcd(w.clock_minute_bcd, MinMax);
    sc = from_bcd(w.clock_second_bcd, SecMax);
    if (w.press_time_mode) begin
      time_sel_q = sel_e'(2'(time_sel_q + 1));
    end
    if (w.press_alarm_mode) begin
      alarm_sel_q = sel_e'(2'(alarm_sel_q + 1));
    end
    case (time_sel_q)
      SelSecond: sc = nudge(sc, SecMax, w.press_up, w.press_down);
      SelMinute: mn = nudge(mn, MinMax, w.press_up, w.press_down);
      SelHour:   hr = nudge(hr, HourMax, w.press_up, w.press_down);
      default: ;
    endcase
    case (alarm_sel_q)
      SelSecond: al_second = 6'(nudge(al_second, SecMax, w.press_up, w.press_down));
      SelMinute: al_minute = 6'(nudge(al_minute, MinMax, w.press_up, w.press_down));
      SelHour:   al_hour = 5'(nudge(al_hour, HourMax, w.press_up, w.press_down));
      default: ;
    endcase
    raw = $unsigned(w.temp_raw);
    neg = w.temp_raw[11];
    mag = neg ? 4096 - raw : raw;
    deg = (mag + 8) >> 4;
    r.set_hour_bcd     = 6'(to_bcd(hr));
    r.set_minute_bcd   = to_bcd(mn);
    r.set_second_bcd   = to_bcd(sc);
    r.write_clock      = (time_sel_q != SelOff);
    r.alarm_ring       = (hr == al_hour) && (mn == al_minute) && (sc == al_second);
    r.temp_degrees     = 8'(deg);
    r.over_temp        = !neg && (deg >= thr_q);
    r.time_field_sel   = time_sel_q;
    r.alarm_field_sel  = alarm_sel_q;
    r.alarm_hour_now   = al_hour;
    r.alarm_minute_now = al_minute;
    r.alarm_second_now = al_second;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (n_err < 100) begin
      $display("[%0t] word %0d %s: got %0d want %0d", $realtime, n_out, what, got, want);
    end
    n_err++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic check_word(out_t got);
    out_t want;
    want = expected_words.pop_front();
    check_field("set_hour_bcd", got.set_hour_bcd, want.set_hour_bcd);
    check_field("set_minute_bcd", got.set_minute_bcd, want.set_minute_bcd);
    check_field("set_second_bcd", got.set_second_bcd, want.set_second_bcd);
    check_field("write_clock", got.write_clock, want.write_clock);
    check_field("alarm_ring", got.alarm_ring, want.alarm_ring);
    check_field("temp_degrees", got.temp_degrees, want.temp_degrees);
    check_field("over_temp", got.over_temp, want.over_temp);
    check_field("time_field_sel", got.time_field_sel, want.time_field_sel);
    check_field("alarm_field_sel", got.alarm_field_sel, want.alarm_field_sel);
    check_field("alarm_hour_now", got.alarm_hour_now, want.alarm_hour_now);
    check_field("alarm_minute_now", got.alarm_minute_now, want.alarm_minute_now);
    check_field("alarm_second_now", got.alarm_second_now, want.alarm_second_now);
  endtask

  // result monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      n_ring += out_data_o.alarm_ring;
      n_over += out_data_o.over_temp;
      n_write += out_data_o.write_clock;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 8'd0, 8'd0);
      end else begin
        check_word(out_data_o);
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("timeout: no handshake for %0d cycles", StallLimit);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(in_t w, bit has_lit, out_t lit);
    out_t want;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    want = step_clock(w);
    if (has_lit) begin
      want = lit;
    end
    expected_words.push_back(want);
    n_in++;
  endtask

  task automatic write_threshold(logic [6:0] v);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_q = v;
    n_cfg++;
  endtask

  function automatic in_t mk(logic [5:0] h, logic [6:0] m, logic [6:0] s, int t,
                             bit tm, bit am, bit up, bit dn);
    in_t r;
    r.clock_hour_bcd   = h;
    r.clock_minute_bcd = m;
    r.clock_second_bcd = s;
    r.temp_raw         = 12'(t);
    r.press_time_mode  = tm;
    r.press_alarm_mode = am;
    r.press_up         = up;
    r.press_down       = dn;
    return r;
  endfunction

  task automatic add_row(in_t w);
    plan.push_back('{w: w, has_lit: 1'b0, lit: '0});
  endtask

  task automatic add_checked(in_t w, out_t lit);
    plan.push_back('{w: w, has_lit: 1'b1, lit: lit});
  endtask

  // random word; clock often parked on the alarm, temperature near the threshold
  function automatic in_t rand_word();
    in_t r;
    int  pick;
    int  t;
    int  edges[10] = '{0, 1, -1, 7, 8, -8, -9, 2047, -2048, 2040};
    r = in_t'($urandom);
    r.press_time_mode  = ($urandom_range(5) == 0);
    r.press_alarm_mode = ($urandom_range(5) == 0);
    r.press_up         = ($urandom_range(2) == 0);
    r.press_down       = ($urandom_range(2) == 0);
    pick = $urandom_range(9);
    if (pick < 3) begin
      r.clock_hour_bcd   = 6'(to_bcd(al_hour));
      r.clock_minute_bcd = to_bcd(al_minute);
      r.clock_second_bcd = to_bcd(al_second);
    end else if (pick < 8) begin
      r.clock_hour_bcd   = 6'(to_bcd($urandom_range(23)));
      r.clock_minute_bcd = to_bcd($urandom_range(59));
      r.clock_second_bcd = to_bcd($urandom_range(59));
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      r.temp_raw = 12'(edges[$urandom_range(9)]);
    end else if (pick < 3) begin
      t = int'(thr_q) * 16 - 9 + int'($urandom_range(2));
      r.temp_raw = 12'((t > 2047) ? 2047 : t);
    end
    return r;
  endfunction

  initial begin
    logic [6:0] thr_next;
    // reset view, clamped BCD, temperature extremes and rounding edges
    add_checked(mk(6'h12, 7'h00, 7'h20, 0, 0, 0, 0, 0),
                out_t'{6'h12, 7'h00, 7'h20, 1'b0, 1'b1, 8'd0, 1'b0,
                       SelOff, SelOff, 5'd12, 6'd0, 6'd20});
    add_checked(mk(6'h3f, 7'h7f, 7'h7f, 2047, 0, 0, 0, 0),
                out_t'{6'h23, 7'h59, 7'h59, 1'b0, 1'b0, 8'd128, 1'b1,
                       SelOff, SelOff, 5'd12, 6'd0, 6'd20});
    add_checked(mk(6'h00, 7'h00, 7'h00, -2048, 0, 0, 0, 0),
                out_t'{6'h00, 7'h00, 7'h00, 1'b0, 1'b0, 8'd128, 1'b0,
                       SelOff, SelOff, 5'd12, 6'd0, 6'd20});
    add_checked(mk(6'h09, 7'h0a, 7'h5a, -1, 0, 0, 0, 0),
                out_t'{6'h09, 7'h10, 7'h59, 1'b0, 1'b0, 8'd0, 1'b0,
                       SelOff, SelOff, 5'd12, 6'd0, 6'd20});
    add_checked(mk(6'h23, 7'h59, 7'h00, 8, 0, 0, 0, 0),
                out_t'{6'h23, 7'h59, 7'h00, 1'b0, 1'b0, 8'd1, 1'b0,
                       SelOff, SelOff, 5'd12, 6'd0, 6'd20});
    add_checked(mk(6'h12, 7'h00, 7'h21, 392, 0, 0, 0, 0),
                out_t'{6'h12, 7'h00, 7'h21, 1'b0, 1'b0, 8'd25, 1'b1,
                       SelOff, SelOff, 5'd12, 6'd0, 6'd20});
    add_row(mk(6'h12, 7'h00, 7'h22, 391, 0, 0, 1, 1));   // selectors off: keys do nothing
    add_row(mk(6'h12, 7'h00, 7'h59, 7, 1, 0, 1, 0));     // second, up wraps
    add_row(mk(6'h12, 7'h00, 7'h00, -8, 0, 0, 0, 1));    // second, down wraps
    add_row(mk(6'h12, 7'h00, 7'h30, 100, 0, 0, 1, 1));   // up then down
    add_row(mk(6'h12, 7'h59, 7'h20, 200, 1, 0, 1, 0));   // minute
    add_row(mk(6'h23, 7'h10, 7'h20, 300, 1, 0, 1, 0));   // hour, up wraps
    add_row(mk(6'h00, 7'h10, 7'h20, 400, 0, 0, 0, 1));   // hour, down wraps
    add_row(mk(6'h05, 7'h10, 7'h20, 500, 1, 0, 1, 0));   // back to off
    add_row(mk(6'h05, 7'h10, 7'h20, 0, 0, 1, 1, 0));     // alarm second up
    add_row(mk(6'h05, 7'h10, 7'h20, 0, 0, 0, 0, 1));
    add_row(mk(6'h05, 7'h10, 7'h20, 0, 0, 1, 0, 1));     // alarm minute wraps down
    add_row(mk(6'h05, 7'h10, 7'h20, 0, 0, 1, 1, 0));     // alarm hour up
    add_row(mk(6'h13, 7'h59, 7'h20, 0, 0, 1, 0, 0));     // alarm off, clock on alarm
    add_row(mk(6'h13, 7'h59, 7'h19, 0, 1, 1, 1, 0));     // both step, alarm second moves on so no match
    add_row(mk(6'h13, 7'h59, 7'h20, -2047, 1, 1, 1, 1));

    tx_idle_pct = 8;
    rx_idle_pct = 83;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_word(plan[i].w, plan[i].has_lit, plan[i].lit);
    end
    in_valid_i <= 1'b0;

    for (int c = 0; c < NumChunks; c++) begin
      case (c)
        0: thr_next = 7'd0;
        1: thr_next = 7'd127;
        2: thr_next = 7'($urandom);
        3: thr_next = 7'd64;
        4: thr_next = ThrReset;
        default: thr_next = 7'($urandom_range(126, 1));
      endcase
      write_threshold(thr_next);
      tx_idle_pct = (c < 2) ? 8 : (c < 4) ? 83 : 0;
      rx_idle_pct = (c < 2) ? 83 : (c < 4) ? 8 : 0;
      // long receiver hold-off so both pipeline stages fill and input stalls
      if (c == 1 || c == 4) begin
        hold_left = 64;
      end
      for (int k = 0; k < ChunkWords; k++) begin
        send_word(rand_word(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d words in, %0d out, %0d threshold writes", n_in, n_out, n_cfg);
    $display("alarm matches %0d, over-temperature %0d, write-back %0d",
             n_ring, n_over, n_write);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
